@@ design/bps_pkg.sv @@
// ----------------------------------------------------------------------------
// bps_pkg
// Shared types and codes for the blink pattern sequencer: command codes,
// timer modes and the packed command and result beats.
// ----------------------------------------------------------------------------
package bps_pkg;

    // Fixed field widths of the command and result beats
    localparam int FUNC_W     = 4;
    localparam int DUR_IN_W   = 16;
    localparam int STEP_IDX_W = 4;

    // Command codes carried in the func field
    typedef enum logic [FUNC_W-1:0] {
        FN_TICK         = 4'd0,
        FN_CLEAR        = 4'd1,
        FN_APPEND_TIMED = 4'd2,
        FN_APPEND_HOLD  = 4'd3,
        FN_MARK_LOOP    = 4'd4,
        FN_START        = 4'd5,
        FN_SET          = 4'd6,
        FN_TOGGLE       = 4'd7,
        FN_IMPULSE      = 4'd8
    } func_t;

    // Timer modes
    typedef enum logic [1:0] {
        MODE_IDLE    = 2'd0,
        MODE_PATTERN = 2'd1,
        MODE_IMPULSE = 2'd2
    } mode_t;

    // One command beat
    typedef struct packed {
        logic [FUNC_W-1:0]   func;
        logic [DUR_IN_W-1:0] duration;
        logic                level;
    } item_t;

    // One result beat
    typedef struct packed {
        logic                  out_level;
        logic                  running;
        logic [STEP_IDX_W-1:0] step_index;
        logic                  level_written;
        logic                  rejected;
    } result_t;

endpackage

@@ design/bps_if.sv @@
// ----------------------------------------------------------------------------
// bps_if
// Valid/ready channels of the blink pattern sequencer: the command channel
// and the result channel.
// ----------------------------------------------------------------------------
interface bps_cmd_if import bps_pkg::*; ();

    logic                valid;
    logic                ready;
    logic [FUNC_W-1:0]   func;
    logic [DUR_IN_W-1:0] duration;
    logic                level;

    modport source (output valid, output func, output duration, output level,
                    input ready);
    modport sink   (input valid, input func, input duration, input level,
                    output ready);

endinterface

interface bps_rsp_if import bps_pkg::*; ();

    logic                  valid;
    logic                  ready;
    logic                  out_level;
    logic                  running;
    logic [STEP_IDX_W-1:0] step_index;
    logic                  level_written;
    logic                  rejected;

    modport source (output valid, output out_level, output running,
                    output step_index, output level_written, output rejected,
                    input ready);
    modport sink   (input valid, input out_level, input running,
                    input step_index, input level_written, input rejected,
                    output ready);

endinterface

@@ design/bps_ram.sv @@
// ----------------------------------------------------------------------------
// bps_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bps_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write on enable, read every cycle
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ design/bps_core.sv @@
// ----------------------------------------------------------------------------
// bps_core
// Sequencer state and next-state logic: step table bookkeeping, pattern and
// impulse timers, output level. The entry of the step that would follow the
// current one is prefetched through the registered table RAM read; entry zero is
// kept in a shadow register for start.
// ----------------------------------------------------------------------------
module bps_core import bps_pkg::*; #(
    parameter  int MAX_STEPS     = 16,
    parameter  int DURATION_BITS = 16,
    localparam int IDX_W         = $clog2(MAX_STEPS),
    localparam int CNT_W         = $clog2(MAX_STEPS + 1),
    localparam int ENT_W         = DURATION_BITS + 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic             cfg_wdata,
    input  logic             fire,
    input  item_t            item,
    output result_t          result,
    output logic             mem_we,
    output logic [IDX_W-1:0] mem_waddr,
    output logic [ENT_W-1:0] mem_wdata,
    output logic [IDX_W-1:0] mem_raddr,
    input  logic [ENT_W-1:0] mem_rdata
);

    // State
    logic                     enabled_reg, enabled_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic [CNT_W-1:0]         loop_reg, loop_next;
    logic                     marked_reg, marked_next;
    logic                     nal_reg, nal_next;
    logic                     out_reg, out_next;
    logic [IDX_W-1:0]         cur_reg, cur_next;
    logic [DURATION_BITS-1:0] rem_reg, rem_next;
    mode_t                    mode_reg, mode_next;
    logic                     first_level_reg, first_level_next;
    logic [DURATION_BITS-1:0] first_dur_reg, first_dur_next;

    // Working values
    logic [CNT_W-1:0]         adv_step;
    logic                     adv_ok;
    logic                     pattern_on;
    logic                     table_full;
    logic [DURATION_BITS-1:0] rem_dec;
    logic [DURATION_BITS-1:0] dur_in;
    logic                     pf_level;
    logic [DURATION_BITS-1:0] pf_dur;
    logic                     wrote;
    logic                     rej;

    // Step after cur, wrapping to the loop mark past the last step
    function automatic logic [CNT_W-1:0] next_step(
        input logic [IDX_W-1:0] cur,
        input logic [CNT_W-1:0] cnt,
        input logic [CNT_W-1:0] lp,
        input logic             mk
    );
        logic [CNT_W-1:0] n;
        n = CNT_W'(cur) + CNT_W'(1);
        if ((n == cnt) && mk && (lp < cnt))
        begin
            n = lp;
        end
        return n;
    endfunction

    // Zero length plays as one tick
    function automatic logic [DURATION_BITS-1:0] clip(
        input logic [DURATION_BITS-1:0] d
    );
        return (d == '0) ? DURATION_BITS'(1) : d;
    endfunction

    assign pf_level = mem_rdata[ENT_W-1];
    assign pf_dur   = mem_rdata[DURATION_BITS-1:0];

    // Next state and result
    always_comb
    begin
        enabled_next     = cfg_we ? cfg_wdata : enabled_reg;
        count_next       = count_reg;
        loop_next        = loop_reg;
        marked_next      = marked_reg;
        nal_next         = nal_reg;
        out_next         = out_reg;
        cur_next         = cur_reg;
        rem_next         = rem_reg;
        mode_next        = mode_reg;
        first_level_next = first_level_reg;
        first_dur_next   = first_dur_reg;
        wrote            = 1'b0;
        rej              = 1'b0;
        mem_we           = 1'b0;
        mem_waddr        = IDX_W'(count_reg);
        mem_wdata        = '0;

        adv_step   = next_step(cur_reg, count_reg, loop_reg, marked_reg);
        adv_ok     = adv_step < count_reg;
        pattern_on = (mode_reg == MODE_PATTERN);
        table_full = (count_reg == CNT_W'(MAX_STEPS));
        rem_dec    = (rem_reg != '0) ? rem_reg - DURATION_BITS'(1) : rem_reg;
        dur_in     = DURATION_BITS'(item.duration);

        if (fire)
        begin
            unique case (item.func)
                FN_TICK:
                begin
                    if (mode_reg != MODE_IDLE)
                    begin
                        rem_next = rem_dec;
                        if (rem_dec == '0)
                        begin
                            if (mode_reg == MODE_IMPULSE)
                            begin
                                // Impulse over: drive low if enabled
                                mode_next = MODE_IDLE;
                                if (enabled_reg)
                                begin
                                    out_next = 1'b0;
                                    wrote    = 1'b1;
                                end
                            end
                            else if (adv_ok)
                            begin
                                // Advance to the prefetched step
                                cur_next  = IDX_W'(adv_step);
                                mode_next = MODE_PATTERN;
                                rem_next  = clip(pf_dur);
                                if (enabled_reg)
                                begin
                                    out_next = pf_level;
                                    wrote    = 1'b1;
                                end
                            end
                            else
                            begin
                                mode_next = MODE_IDLE;
                            end
                        end
                    end
                end
                FN_CLEAR:
                begin
                    count_next  = '0;
                    loop_next   = '0;
                    marked_next = 1'b0;
                    nal_next    = 1'b1;
                    mode_next   = MODE_IDLE;
                end
                FN_APPEND_TIMED, FN_APPEND_HOLD:
                begin
                    if (pattern_on || table_full)
                    begin
                        rej = 1'b1;
                    end
                    else
                    begin
                        mem_we = 1'b1;
                        if (item.func == FN_APPEND_TIMED)
                        begin
                            mem_wdata = {nal_reg, dur_in};
                            nal_next  = ~nal_reg;
                        end
                        else
                        begin
                            mem_wdata = {out_reg, {DURATION_BITS{1'b0}}};
                        end
                        // Shadow entry zero for start
                        if (count_reg == '0)
                        begin
                            first_level_next = mem_wdata[ENT_W-1];
                            first_dur_next   = mem_wdata[DURATION_BITS-1:0];
                        end
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                FN_MARK_LOOP:
                begin
                    if (pattern_on || table_full)
                    begin
                        rej = 1'b1;
                    end
                    else if (!marked_reg)
                    begin
                        marked_next = 1'b1;
                        loop_next   = count_reg;
                    end
                end
                FN_START:
                begin
                    mode_next = MODE_IDLE;
                    cur_next  = '0;
                    if (count_reg != '0)
                    begin
                        mode_next = MODE_PATTERN;
                        rem_next  = clip(first_dur_reg);
                        if (enabled_reg)
                        begin
                            out_next = first_level_reg;
                            wrote    = 1'b1;
                        end
                    end
                end
                FN_SET, FN_TOGGLE:
                begin
                    mode_next = MODE_IDLE;
                    if (enabled_reg)
                    begin
                        out_next = (item.func == FN_SET) ? item.level : ~out_reg;
                        wrote    = 1'b1;
                    end
                end
                FN_IMPULSE:
                begin
                    mode_next = MODE_IMPULSE;
                    rem_next  = clip(dur_in);
                    if (enabled_reg)
                    begin
                        out_next = 1'b1;
                        wrote    = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end

        // Prefetch the entry that would follow the next state's step
        mem_raddr = IDX_W'(next_step(cur_next, count_next, loop_next, marked_next));

        result.out_level     = out_next;
        result.running       = (mode_next != MODE_IDLE);
        result.step_index    = STEP_IDX_W'(cur_next);
        result.level_written = wrote;
        result.rejected      = rej;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg <= 1'b1;
            count_reg   <= '0;
            loop_reg    <= '0;
            marked_reg  <= 1'b0;
            nal_reg     <= 1'b1;
            out_reg     <= 1'b0;
            cur_reg     <= '0;
            rem_reg     <= '0;
            mode_reg    <= MODE_IDLE;
        end
        else
        begin
            enabled_reg <= enabled_next;
            count_reg   <= count_next;
            loop_reg    <= loop_next;
            marked_reg  <= marked_next;
            nal_reg     <= nal_next;
            out_reg     <= out_next;
            cur_reg     <= cur_next;
            rem_reg     <= rem_next;
            mode_reg    <= mode_next;
        end
    end

    // Shadow of table entry zero
    always_ff @(posedge clk)
    begin
        first_level_reg <= first_level_next;
        first_dur_reg   <= first_dur_next;
    end

endmodule

@@ design/blink_pattern_sequencer.sv @@
// ----------------------------------------------------------------------------
// blink_pattern_sequencer
// Drives one boolean level from a table of timed pattern steps or from a
// single impulse; commands and millisecond ticks arrive as command beats.
// ----------------------------------------------------------------------------
// Path: an accepted command beat goes to the input register, its result
//   then to the result register; a stalled result side holds both.
// Throughput: one beat per cycle unless the result side stalls; the
//   next entry is prefetched from the step table RAM, ready for a tick.
// Reset: asynchronous, active low; table empty, level low, timers idle,
//   enabled set. Table entries are not cleared.
module blink_pattern_sequencer import bps_pkg::*; #(
    parameter int MAX_STEPS     = 16,
    parameter int DURATION_BITS = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cfg_we,
    input  logic      cfg_wdata,
    bps_cmd_if.sink   cmd,
    bps_rsp_if.source rsp
);

    localparam int IDX_W = $clog2(MAX_STEPS);
    localparam int ENT_W = DURATION_BITS + 1;

    logic             s1_valid_reg;
    item_t            s1_item_reg;
    logic             rsp_valid_reg;
    result_t          rsp_data_reg;
    logic             adv;
    logic             fire;
    result_t          core_result;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [ENT_W-1:0] mem_wdata;
    logic [IDX_W-1:0] mem_raddr;
    logic [ENT_W-1:0] mem_rdata;

    // Handshake: move the input beat on when the result slot is free
    assign adv       = !rsp_valid_reg || rsp.ready;
    assign fire      = s1_valid_reg && adv;
    assign cmd.ready = !s1_valid_reg || adv;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (cmd.ready)
        begin
            s1_valid_reg <= cmd.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
        begin
            s1_item_reg.func     <= cmd.func;
            s1_item_reg.duration <= cmd.duration;
            s1_item_reg.level    <= cmd.level;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            rsp_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            rsp_data_reg <= core_result;
        end
    end

    assign rsp.valid         = rsp_valid_reg;
    assign rsp.out_level     = rsp_data_reg.out_level;
    assign rsp.running       = rsp_data_reg.running;
    assign rsp.step_index    = rsp_data_reg.step_index;
    assign rsp.level_written = rsp_data_reg.level_written;
    assign rsp.rejected      = rsp_data_reg.rejected;

    bps_core #(
        .MAX_STEPS     (MAX_STEPS),
        .DURATION_BITS (DURATION_BITS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .fire      (fire),
        .item      (s1_item_reg),
        .result    (core_result),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    bps_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_STEPS)
    ) u_table (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule

@@ design/bps_checker.sv @@
// ----------------------------------------------------------------------------
// bps_checker
// Port-level checks for the blink pattern sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module bps_checker import bps_pkg::*; (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  cmd_ready,
    input logic                  rsp_valid,
    input logic                  rsp_ready,
    input logic                  rsp_out_level,
    input logic                  rsp_running,
    input logic [STEP_IDX_W-1:0] rsp_step_index,
    input logic                  rsp_level_written,
    input logic                  rsp_rejected
);

    // Hold a stalled result beat
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid &&
            $stable({rsp_out_level, rsp_running, rsp_step_index,
                     rsp_level_written, rsp_rejected}))
        else $error("result beat changed while stalled");

    // Never stall commands while the result side drains
    a_no_bubble: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_ready |-> cmd_ready)
        else $error("command side stalled with result side ready");

    // A refused append or loop mark never writes the level
    a_rej_nowrite: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_rejected |-> !rsp_level_written)
        else $error("rejected beat reports a level write");

endmodule

bind blink_pattern_sequencer bps_checker u_bps_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd_ready         (cmd.ready),
    .rsp_valid         (rsp.valid),
    .rsp_ready         (rsp.ready),
    .rsp_out_level     (rsp.out_level),
    .rsp_running       (rsp.running),
    .rsp_step_index    (rsp.step_index),
    .rsp_level_written (rsp.level_written),
    .rsp_rejected      (rsp.rejected)
);

@@ verif/bps_checker.sv @@
// ----------------------------------------------------------------------------
// bps_scoreboard
// Watches the command, result and register ports of the blink pattern
// sequencer. It keeps its own copy of the step table, timers and output level,
// works out the result of every accepted command beat and compares each
// result beat, field by field, with the oldest expectation.
// ----------------------------------------------------------------------------
module bps_scoreboard import bps_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_we,
    input  logic cfg_wdata,
    bps_cmd_if   cmd,
    bps_rsp_if   rsp,
    output int   fail_total,
    output int   beats_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_DEPTH = 16;

    // Shadow state of the sequencer
    logic                step_lvl [TABLE_DEPTH];
    logic [DUR_IN_W-1:0] step_dur [TABLE_DEPTH];
    int unsigned         n_steps;
    int unsigned         loop_at;
    bit                  loop_set;
    bit                  next_lvl;
    bit                  level_q;
    bit                  lvl_enable;
    bit                  wrote;
    int unsigned         cur_step;
    logic [DUR_IN_W-1:0] ticks_left;
    mode_t               mode;

    result_t result_q [$];
    int      errors;
    int      rsp_count;

    // Zero duration plays as one tick
    function automatic logic [DUR_IN_W-1:0] clip_ticks(logic [DUR_IN_W-1:0] d);
        return (d == '0) ? DUR_IN_W'(1) : d;
    endfunction

    // Level write: stops every timer, lands only while enabled
    function automatic void drive_level(bit v);
        mode = MODE_IDLE;
        if (lvl_enable)
        begin
            level_q = v;
            wrote   = 1'b1;
        end
    endfunction

    function automatic void play_step(int unsigned idx);
        cur_step = idx;
        drive_level(step_lvl[idx]);
        mode       = MODE_PATTERN;
        ticks_left = clip_ticks(step_dur[idx]);
    endfunction

    // Advance the shadow state by one command beat and return its result
    function automatic result_t predict_beat(item_t it);
        result_t     r;
        bit          refused;
        bit          playing;
        int unsigned nxt;

        refused = 1'b0;
        playing = (mode == MODE_PATTERN);
        wrote   = 1'b0;

        case (it.func)
            FN_TICK:
            begin
                if (mode != MODE_IDLE)
                begin
                    if (ticks_left != '0)
                        ticks_left = ticks_left - 1'b1;
                    if (ticks_left == '0)
                    begin
                        if (mode == MODE_IMPULSE)
                            drive_level(1'b0);
                        else
                        begin
                            // wrap to the loop mark only when it lies inside the table
                            nxt = cur_step + 1;
                            if (nxt == n_steps && loop_set && loop_at < n_steps)
                                nxt = loop_at;
                            if (nxt >= n_steps || nxt >= TABLE_DEPTH)
                                mode = MODE_IDLE;
                            else
                                play_step(nxt);
                        end
                    end
                end
            end
            FN_CLEAR:
            begin
                n_steps  = 0;
                loop_at  = 0;
                loop_set = 1'b0;
                next_lvl = 1'b1;
                mode     = MODE_IDLE;
            end
            FN_APPEND_TIMED, FN_APPEND_HOLD:
            begin
                if (playing || n_steps >= TABLE_DEPTH)
                    refused = 1'b1;
                else
                begin
                    if (it.func == FN_APPEND_TIMED)
                    begin
                        step_lvl[n_steps] = next_lvl;
                        step_dur[n_steps] = it.duration;
                        next_lvl          = !next_lvl;
                    end
                    else
                    begin
                        step_lvl[n_steps] = level_q;
                        step_dur[n_steps] = '0;
                    end
                    n_steps++;
                end
            end
            FN_MARK_LOOP:
            begin
                if (playing || n_steps >= TABLE_DEPTH)
                    refused = 1'b1;
                else if (!loop_set)
                begin
                    loop_set = 1'b1;
                    loop_at  = n_steps;
                end
            end
            FN_START:
            begin
                mode     = MODE_IDLE;
                cur_step = 0;
                if (n_steps > 0)
                    play_step(0);
            end
            FN_SET:
                drive_level(it.level);
            FN_TOGGLE:
                drive_level(!level_q);
            FN_IMPULSE:
            begin
                drive_level(1'b1);
                mode       = MODE_IMPULSE;
                ticks_left = clip_ticks(it.duration);
            end
            default:
            begin
            end
        endcase

        r.out_level     = level_q;
        r.running       = (mode != MODE_IDLE);
        r.step_index    = cur_step[STEP_IDX_W-1:0];
        r.level_written = wrote;
        r.rejected      = refused;
        return r;
    endfunction

    task automatic report(string msg);
        $display("%0t ns result %0d: %s", $realtime, rsp_count, msg);
        errors++;
    endtask

    task automatic compare_field(string name, logic [3:0] got, logic [3:0] want);
        if (got !== want)
            report($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    // Track register writes, predict on command beats, check result beats
    always @(posedge clk or negedge rst_n)
    begin : watch
        item_t   beat;
        result_t want;
        result_t pred;

        if (!rst_n)
        begin
            for (int i = 0; i < TABLE_DEPTH; i++)
            begin
                step_lvl[i] = 1'b0;
                step_dur[i] = '0;
            end
            n_steps    = 0;
            loop_at    = 0;
            loop_set   = 1'b0;
            next_lvl   = 1'b1;
            level_q    = 1'b0;
            cur_step   = 0;
            ticks_left = '0;
            mode       = MODE_IDLE;
            lvl_enable = 1'b1;
            errors     = 0;
            rsp_count  = 0;
            result_q.delete();
        end
        else
        begin
            if (cfg_we)
                lvl_enable = cfg_wdata;

            // check the oldest expectation first so a stray beat never meets a new one
            if (rsp.valid && rsp.ready)
            begin
                if (result_q.size() == 0)
                    report("result beat with no command waiting");
                else
                begin
                    want = result_q.pop_front();
                    compare_field("out_level", 4'(rsp.out_level), 4'(want.out_level));
                    compare_field("running", 4'(rsp.running), 4'(want.running));
                    compare_field("step_index", rsp.step_index, want.step_index);
                    compare_field("level_written", 4'(rsp.level_written),
                                  4'(want.level_written));
                    compare_field("rejected", 4'(rsp.rejected), 4'(want.rejected));
                end
                rsp_count++;
            end

            if (cmd.valid && cmd.ready)
            begin
                beat.func     = cmd.func;
                beat.duration = cmd.duration;
                beat.level    = cmd.level;
                pred          = predict_beat(beat);
                result_q.insert(result_q.size(), pred);
            end
        end
        fail_total    <= errors;
        beats_pending <= result_q.size();
    end

endmodule

@@ verif/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the blink pattern sequencer. A directed opening
// covers the command codes and corner cases, then random pattern, impulse,
// level and noise sequences run under each setting of the enable register,
// with random gaps on the command side and random stalls on the result side.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import bps_pkg::*;

    localparam int PHASE_BEATS = 390;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_wdata;
    int   fail_total;
    int   beats_pending;
    bit   cmd_calm;
    bit   rsp_calm;
    int   beats_sent;

    bps_cmd_if cmd_ch ();
    bps_rsp_if rsp_ch ();

    blink_pattern_sequencer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd_ch),
        .rsp       (rsp_ch)
    );

    bps_scoreboard u_chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .cmd           (cmd_ch),
        .rsp           (rsp_ch),
        .fail_total    (fail_total),
        .beats_pending (beats_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Hard stop for a hung run
    initial
    begin
        #10_000_000;
        $display("blink_pattern_sequencer verification failed");
        $finish;
    end

    function automatic int draw_gap(bit calm);
        return calm ? 0 : $urandom_range(0, 14);
    endfunction

    // Mostly short step lengths so patterns play out, now and then zero or any value
    function automatic logic [DUR_IN_W-1:0] short_dur();
        case ($urandom_range(0, 15))
            0:       return DUR_IN_W'($urandom);
            1:       return '0;
            default: return DUR_IN_W'($urandom_range(1, 4));
        endcase
    endfunction

    // Present one command beat after a random gap and hold it until taken
    task automatic send_beat(logic [FUNC_W-1:0] f, logic [DUR_IN_W-1:0] d, logic l);
        int gap;

        if ($urandom_range(0, 39) == 0)
            cmd_calm = !cmd_calm;
        gap = draw_gap(cmd_calm);
        if (gap > 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_ch.valid    <= 1'b1;
        cmd_ch.func     <= f;
        cmd_ch.duration <= d;
        cmd_ch.level    <= l;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
        if (f <= FN_IMPULSE)
            beats_sent++;
    endtask

    // Drop valid and hold off until every expected result has come back
    task automatic drain();
        cmd_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (beats_pending != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_enable(bit v);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    // Result side: stall a random number of cycles before each beat
    initial
    begin : rsp_side
        int gap;

        rsp_ch.ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 39) == 0)
                rsp_calm = !rsp_calm;
            gap = draw_gap(rsp_calm);
            if (gap > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!rsp_ch.valid);
        end
    end

    initial
    begin : stimulus
        int n;
        int mark_at;
        int target;

        rst_n           <= 1'b0;
        cfg_we          <= 1'b0;
        cfg_wdata       <= 1'b0;
        cmd_ch.valid    <= 1'b0;
        cmd_ch.func     <= FN_TICK;
        cmd_ch.duration <= '0;
        cmd_ch.level    <= 1'b0;
        beats_sent = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Tick while idle, then a hold-old step that captures a high level
        send_beat(FN_TICK, '0, 1'b0);
        send_beat(FN_SET, '0, 1'b1);
        send_beat(FN_APPEND_HOLD, '0, 1'b0);
        send_beat(FN_TOGGLE, '0, 1'b0);
        // Zero-length timed step, loop mark, ignored second mark
        send_beat(FN_APPEND_TIMED, '0, 1'b0);
        send_beat(FN_MARK_LOOP, '0, 1'b0);
        send_beat(FN_MARK_LOOP, '0, 1'b0);
        send_beat(FN_APPEND_TIMED, 16'd2, 1'b0);
        send_beat(FN_APPEND_TIMED, 16'd1, 1'b0);
        // Play; appends and marks are refused while the pattern runs
        send_beat(FN_START, '0, 1'b0);
        send_beat(FN_APPEND_TIMED, 16'd3, 1'b0);
        send_beat(FN_MARK_LOOP, '0, 1'b0);
        repeat (6) send_beat(FN_TICK, '0, 1'b0);
        // Longest impulse cut short by a one-tick impulse that then ends
        send_beat(FN_IMPULSE, 16'hFFFF, 1'b0);
        send_beat(FN_IMPULSE, '0, 1'b0);
        send_beat(FN_TICK, '0, 1'b0);
        // Clear, unused codes, explicit low
        send_beat(FN_CLEAR, '0, 1'b0);
        send_beat(4'd9, 16'hA5A5, 1'b1);
        send_beat(4'd15, 16'hFFFF, 1'b1);
        send_beat(FN_SET, '0, 1'b0);

        for (int ph = 0; ph < 5; ph++)
        begin
            set_enable(ph % 2 == 1);
            target = beats_sent + PHASE_BEATS;
            while (beats_sent < target)
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5:
                    begin
                        // Build a table, maybe mark a loop, play it on ticks
                        if ($urandom_range(0, 4) != 0)
                            send_beat(FN_CLEAR, 16'($urandom), 1'($urandom));
                        n = ($urandom_range(0, 3) == 0) ? $urandom_range(15, 18)
                                                        : $urandom_range(1, 6);
                        mark_at = $urandom_range(0, n + 1);
                        for (int i = 0; i <= n; i++)
                        begin
                            if (i == mark_at)
                            begin
                                send_beat(FN_MARK_LOOP, 16'($urandom), 1'($urandom));
                                if ($urandom_range(0, 5) == 0)
                                    send_beat(FN_MARK_LOOP, 16'($urandom), 1'($urandom));
                            end
                            if (i < n)
                            begin
                                if ($urandom_range(0, 7) == 0)
                                    send_beat(FN_TOGGLE, 16'($urandom), 1'($urandom));
                                if ($urandom_range(0, 2) == 0)
                                    send_beat(FN_APPEND_HOLD, 16'($urandom), 1'($urandom));
                                else
                                    send_beat(FN_APPEND_TIMED, short_dur(), 1'($urandom));
                            end
                        end
                        if ($urandom_range(0, 9) != 0)
                            send_beat(FN_START, 16'($urandom), 1'($urandom));
                        repeat ($urandom_range(2, 30))
                        begin
                            case ($urandom_range(0, 19))
                                0: send_beat(FN_APPEND_TIMED, short_dur(), 1'($urandom));
                                1: send_beat(FN_MARK_LOOP, 16'($urandom), 1'($urandom));
                                2: send_beat(FN_SET, 16'($urandom), 1'($urandom));
                                3: send_beat(FN_START, 16'($urandom), 1'($urandom));
                                4: send_beat(FN_APPEND_HOLD, 16'($urandom), 1'($urandom));
                                default: send_beat(FN_TICK, 16'($urandom), 1'($urandom));
                            endcase
                        end
                    end
                    6:
                    begin
                        // Impulse played out on ticks, appends allowed meanwhile
                        send_beat(FN_IMPULSE, short_dur(), 1'($urandom));
                        repeat ($urandom_range(0, 8))
                        begin
                            if ($urandom_range(0, 7) == 0)
                                send_beat(FN_APPEND_TIMED, short_dur(), 1'($urandom));
                            else
                                send_beat(FN_TICK, 16'($urandom), 1'($urandom));
                        end
                    end
                    7:
                        repeat ($urandom_range(1, 4))
                            send_beat($urandom_range(0, 1) ? FN_SET : FN_TOGGLE,
                                      16'($urandom), 1'($urandom));
                    8:
                        repeat ($urandom_range(1, 3))
                            send_beat(4'($urandom), 16'($urandom), 1'($urandom));
                    default:
                    begin
                        // Let everything drain, then start, sometimes on an empty table
                        drain();
                        if ($urandom_range(0, 1) == 0)
                            send_beat(FN_CLEAR, 16'($urandom), 1'($urandom));
                        send_beat(FN_START, 16'($urandom), 1'($urandom));
                    end
                endcase
            end
        end

        drain();
        if (fail_total == 0)
            $display("blink_pattern_sequencer verification clean");
        else
            $display("blink_pattern_sequencer verification failed");
        $finish;
    end

endmodule

@@ files.f @@
design/bps_pkg.sv
design/bps_if.sv
design/bps_ram.sv
design/bps_core.sv
design/blink_pattern_sequencer.sv
design/bps_checker.sv
verif/bps_checker.sv
verif/tb_top.sv
